@@ rtl/wsfc_pkg.sv @@
// Shared types and constants for the weighted-sum frame checker.
package wsfc_pkg;

  // Divider datapath widths: sum plus product needs 17 bits, remainder stays in 16
  localparam int unsigned DivWidth = 17;
  localparam int unsigned RemWidth = 16;

  // Fixed frame constants
  localparam logic [7:0] EndMarker = 8'hAA;
  localparam logic [DivWidth-1:0] CheckBase = 17'd255;

  // Register indexes on the configuration port
  localparam logic [1:0] RegLocalAddr = 2'd0;
  localparam logic [1:0] RegBcastAddr = 2'd1;
  localparam logic [1:0] RegModulus   = 2'd2;
  localparam logic [1:0] RegStartCode = 2'd3;

  // Register reset values
  localparam logic [7:0]  LocalAddrRst = 8'd0;
  localparam logic [7:0]  BcastAddrRst = 8'd255;
  localparam logic [15:0] ModulusRst   = 16'd65025;
  localparam logic [7:0]  StartCodeRst = 8'd170;

  // Frame status codes
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusBadEnd   = 2'd1;
  localparam logic [1:0] StatusMismatch = 2'd2;
  localparam logic [1:0] StatusNotOurs  = 2'd3;

endpackage

@@ rtl/weighted_sum_frame_checker_core.sv @@
// Top level of the weighted-sum frame checker: sequencer, frame state, registers.
// A byte at positions 2 to MAX_FRAME-1 runs one 17-step divider pass by the modulus and
// holds rx_ready_o low until that pass is done, so the next byte waits for it.
// Non-end bytes at other positions skip the divider. An end-flagged byte adds a pass by 255;
// its status is valid after that pass and the emit step, once the status register is free.
// Reset (rst_ni low, asynchronous) clears frame state and status and loads register defaults.
module weighted_sum_frame_checker_core #(
  parameter int unsigned MAX_FRAME = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte request channel
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        end_of_frame_i,
  // Status channel
  output logic        status_valid_o,
  input  logic        status_ready_i,
  output logic [1:0]  frame_status_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [5:0] MaxPos = 6'(MAX_FRAME);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_CHK_START,
    ST_CHK,
    ST_EMIT
  } state_e;

  // Configuration registers
  logic [7:0]  local_addr_q;
  logic [7:0]  bcast_addr_q;
  logic [15:0] modulus_q;
  logic [7:0]  start_code_q;
  logic        cfg_write;

  // Sequencer and frame state
  state_e      state_q, state_d;
  logic [5:0]  pos_q, pos_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  rcl_q, rcl_d;
  logic [7:0]  rch_q, rch_d;
  logic [7:0]  prev_q, prev_d;
  logic [7:0]  byte_q, byte_d;
  logic [5:0]  cur_pos_q, cur_pos_d;
  logic [7:0]  sl_q, sl_d;
  logic        last_q, last_d;
  logic [1:0]  pend_q, pend_d;
  logic        status_valid_q, status_valid_d;
  logic [1:0]  status_q, status_d;

  // Divider hookup
  logic                          div_start;
  logic [wsfc_pkg::DivWidth-1:0] div_dividend;
  logic [wsfc_pkg::DivWidth-1:0] div_divisor;
  logic                          div_done;
  logic [wsfc_pkg::DivWidth-1:0] div_quot;
  logic [wsfc_pkg::RemWidth-1:0] div_rem;

  logic                          rx_accept;
  logic [13:0]                   product;
  logic [wsfc_pkg::DivWidth-1:0] modulus_ext;
  logic [7:0]                    hi_raw, lo_raw, hi_chk, lo_chk;
  logic [1:0]                    status_calc;

  // Write registers on the access phase
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q <= wsfc_pkg::LocalAddrRst;
      bcast_addr_q <= wsfc_pkg::BcastAddrRst;
      modulus_q    <= wsfc_pkg::ModulusRst;
      start_code_q <= wsfc_pkg::StartCodeRst;
    end else if (cfg_write) begin
      case (paddr[3:2])
        wsfc_pkg::RegLocalAddr: local_addr_q <= pwdata[7:0];
        wsfc_pkg::RegBcastAddr: bcast_addr_q <= pwdata[7:0];
        wsfc_pkg::RegModulus:   modulus_q    <= pwdata[15:0];
        wsfc_pkg::RegStartCode: start_code_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back registers
  always_comb begin
    case (paddr[3:2])
      wsfc_pkg::RegLocalAddr: prdata = {24'd0, local_addr_q};
      wsfc_pkg::RegBcastAddr: prdata = {24'd0, bcast_addr_q};
      wsfc_pkg::RegModulus:   prdata = {16'd0, modulus_q};
      wsfc_pkg::RegStartCode: prdata = {24'd0, start_code_q};
      default:                prdata = '0;
    endcase
  end

  // Weight the byte by its position; a zero modulus stands for 2^16
  assign product     = {6'd0, rx_byte_i} * {8'd0, pos_q};
  assign modulus_ext = {(modulus_q == 16'd0), modulus_q};

  // Form the check bytes, stepping off the start code
  assign hi_raw = div_quot[7:0];
  assign lo_raw = div_rem[7:0];
  assign hi_chk = (hi_raw == start_code_q) ? hi_raw - 8'd1 : hi_raw;
  assign lo_chk = (lo_raw == start_code_q) ? lo_raw - 8'd1 : lo_raw;

  // Rank the checks: end marker, check bytes, address
  always_comb begin
    if (cur_pos_q < 6'd3 || byte_q != wsfc_pkg::EndMarker) begin
      status_calc = wsfc_pkg::StatusBadEnd;
    end else if (hi_chk != rch_q || lo_chk != rcl_q) begin
      status_calc = wsfc_pkg::StatusMismatch;
    end else if (sl_q != local_addr_q && sl_q != bcast_addr_q) begin
      status_calc = wsfc_pkg::StatusNotOurs;
    end else begin
      status_calc = wsfc_pkg::StatusOk;
    end
  end

  assign rx_ready_o = (state_q == ST_IDLE);
  assign rx_accept  = rx_valid_i && rx_ready_o;

  // Sequence each byte, the passes through the shared divider and the status emit
  always_comb begin
    state_d        = state_q;
    pos_d          = pos_q;
    sum_d          = sum_q;
    rcl_d          = rcl_q;
    rch_d          = rch_q;
    prev_d         = prev_q;
    byte_d         = byte_q;
    cur_pos_d      = cur_pos_q;
    sl_d           = sl_q;
    last_d         = last_q;
    pend_d         = pend_q;
    status_d       = status_q;
    status_valid_d = status_valid_q && !status_ready_i;
    div_start      = 1'b0;
    div_dividend   = '0;
    div_divisor    = '0;

    case (state_q)
      ST_IDLE: begin
        if (rx_accept) begin
          byte_d    = rx_byte_i;
          last_d    = end_of_frame_i;
          cur_pos_d = pos_q;
          sl_d      = prev_q;
          prev_d    = rx_byte_i;
          if (pos_q < MaxPos) begin
            pos_d = pos_q + 6'd1;
          end
          if (pos_q == 6'd0) begin
            rcl_d   = rx_byte_i;
            state_d = end_of_frame_i ? ST_CHK_START : ST_IDLE;
          end else if (pos_q == 6'd1) begin
            rch_d   = rx_byte_i;
            state_d = end_of_frame_i ? ST_CHK_START : ST_IDLE;
          end else if (pos_q < MaxPos) begin
            div_start    = 1'b1;
            div_dividend = {1'b0, sum_q} + wsfc_pkg::DivWidth'(product);
            div_divisor  = modulus_ext;
            state_d      = ST_MOD;
          end else begin
            state_d = end_of_frame_i ? ST_CHK_START : ST_IDLE;
          end
        end
      end
      ST_MOD: begin
        if (div_done) begin
          sum_d   = div_rem;
          state_d = last_q ? ST_CHK_START : ST_IDLE;
        end
      end
      ST_CHK_START: begin
        div_start    = 1'b1;
        div_dividend = {1'b0, sum_q};
        div_divisor  = wsfc_pkg::CheckBase;
        state_d      = ST_CHK;
      end
      ST_CHK: begin
        if (div_done) begin
          pend_d  = status_calc;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Hold until the status register is free, then drop the frame state
        if (!status_valid_q || status_ready_i) begin
          status_d       = pend_q;
          status_valid_d = 1'b1;
          pos_d          = '0;
          sum_d          = '0;
          rcl_d          = '0;
          rch_d          = '0;
          prev_d         = '0;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      pos_q          <= '0;
      sum_q          <= '0;
      rcl_q          <= '0;
      rch_q          <= '0;
      prev_q         <= '0;
      byte_q         <= '0;
      cur_pos_q      <= '0;
      sl_q           <= '0;
      last_q         <= 1'b0;
      pend_q         <= '0;
      status_q       <= '0;
      status_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      pos_q          <= pos_d;
      sum_q          <= sum_d;
      rcl_q          <= rcl_d;
      rch_q          <= rch_d;
      prev_q         <= prev_d;
      byte_q         <= byte_d;
      cur_pos_q      <= cur_pos_d;
      sl_q           <= sl_d;
      last_q         <= last_d;
      pend_q         <= pend_d;
      status_q       <= status_d;
      status_valid_q <= status_valid_d;
    end
  end

  assign status_valid_o = status_valid_q;
  assign frame_status_o = status_q;

  wsfc_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  // Divider results only arrive while the sequencer waits for them
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_MOD || state_q == ST_CHK))
    else $error("divider finished outside a wait state");

  // A new status only appears out of the emit step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(status_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("status raised without an emit");

  // Emitting a status leaves a clean frame behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && (!status_valid_q || status_ready_i))
      |=> (pos_q == 6'd0 && sum_q == 16'd0))
    else $error("frame state not cleared after status");

  // The position counter saturates at the frame limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= MaxPos)
    else $error("byte position beyond frame limit");

endmodule

@@ rtl/wsfc_divider.sv @@
// Shared restoring divider: one quotient bit per cycle, quotient and remainder.
module wsfc_divider (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [wsfc_pkg::DivWidth-1:0]  dividend_i,
  input  logic [wsfc_pkg::DivWidth-1:0]  divisor_i,
  output logic                           done_o,
  output logic [wsfc_pkg::DivWidth-1:0]  quotient_o,
  output logic [wsfc_pkg::RemWidth-1:0]  remainder_o
);

  localparam int unsigned CntW = $clog2(wsfc_pkg::DivWidth);
  localparam logic [CntW-1:0] LastStep = CntW'(wsfc_pkg::DivWidth - 1);

  logic                          busy_q;
  logic                          done_q;
  logic [CntW-1:0]               cnt_q;
  logic [wsfc_pkg::DivWidth-1:0] dq_q, dq_d;
  logic [wsfc_pkg::DivWidth-1:0] div_q;
  logic [wsfc_pkg::RemWidth-1:0] rem_q, rem_d;
  logic [wsfc_pkg::DivWidth-1:0] trial;
  logic                          fits;

  // Shift in the next dividend bit and subtract the divisor when it fits
  always_comb begin
    trial = {rem_q, dq_q[wsfc_pkg::DivWidth-1]};
    fits  = (trial >= div_q);
    if (fits) begin
      rem_d = wsfc_pkg::RemWidth'(trial - div_q);
    end else begin
      rem_d = trial[wsfc_pkg::RemWidth-1:0];
    end
    dq_d = {dq_q[wsfc_pkg::DivWidth-2:0], fits};
  end

  // Load on start, then step until every quotient bit is resolved
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dq_q   <= '0;
      div_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        dq_q   <= dividend_i;
        div_q  <= divisor_i;
        rem_q  <= '0;
      end else if (busy_q) begin
        dq_q  <= dq_d;
        rem_q <= rem_d;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = dq_q;
  assign remainder_o = rem_q;

endmodule
